>>> rtl/core/first_fit_block_allocator_defines.svh
// Assertion macros shared by the allocator files that check their own logic.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFBA_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("allocator check failed");

// The consequent must hold in the cycle after the antecedent.
`define FFBA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

>>> rtl/core/ffba_pkg.sv
// Types, constants and control structs shared by the allocator modules.
package ffba_pkg;

    localparam int MAX_BLOCKS_DEF      = 64;
    localparam int HEADER_BYTES_DEF    = 12;
    localparam int MIN_SPLIT_BYTES_DEF = 8;

    localparam int OFF_W  = 23;
    localparam int SIZE_W = 24;
    localparam int ADDR_W = 32;
    localparam int REQ_W  = 24;
    localparam int ALIGN  = 8;

    localparam logic [SIZE_W-1:0] HEAP_LIMIT = 24'd8388608;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_NULL    = 2'd2,
        ST_UNKNOWN = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        FN_ALLOC = 1'b0,
        FN_FREE  = 1'b1
    } func_t;

    typedef enum logic [0:0] {
        CFG_HEAP_BASE  = 1'b0,
        CFG_HEAP_BYTES = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic              free;
        logic [SIZE_W-1:0] size;
        logic [OFF_W-1:0]  off;
    } entry_t;

    typedef enum logic [1:0] {
        RD_IDX    = 2'd0,
        RD_PTR_DN = 2'd1,
        RD_PTR_UP = 2'd2,
        RD_NEXT   = 2'd3
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_PTR = 2'd0,
        WR_NEW = 2'd1,
        WR_CUR = 2'd2
    } wr_sel_t;

    typedef struct packed {
        logic    load;
        logic    idx_inc;
        logic    cur_ld;
        logic    cur_merge;
        logic    cur_take_need;
        logic    ptr_init_up;
        logic    ptr_init_dn;
        logic    ptr_dec;
        logic    ptr_inc;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    res_ld;
        status_t res_code;
    } cmd_t;

    typedef struct packed {
        logic init_busy;
        logic func_free;
        logic is_null;
        logic idx_end;
        logic fit;
        logic split;
        logic hit;
        logic has_next;
        logic mergeable;
        logic up_done;
        logic dn_done;
    } sts_t;

endpackage

>>> rtl/core/ffba_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module ffba_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/ffba_dpath.sv
// Allocator datapath: block table, counters, request and result registers.
module ffba_dpath #(
    parameter int MAX_BLOCKS      = ffba_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES    = ffba_pkg::HEADER_BYTES_DEF,
    parameter int MIN_SPLIT_BYTES = ffba_pkg::MIN_SPLIT_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic                          cfg_index,
    input  logic [ffba_pkg::ADDR_W-1:0]   cfg_data,
    input  logic [55:0]                   s_tdata,
    input  logic                          s_tuser,
    input  ffba_pkg::cmd_t                cmd,
    output ffba_pkg::sts_t                sts,
    output logic [ffba_pkg::ADDR_W-1:0]   res_address,
    output ffba_pkg::status_t             res_status
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int EW = $bits(ffba_pkg::entry_t);
    localparam logic [25:0] HDR  = 26'(HEADER_BYTES);
    localparam logic [25:0] MINS = 26'(MIN_SPLIT_BYTES);
    localparam logic [24:0] AMSK = 25'(ffba_pkg::ALIGN - 1);

    logic [ffba_pkg::ADDR_W-1:0] base_reg;
    logic [ffba_pkg::SIZE_W-1:0] bytes_reg;
    logic                        init_reg;
    logic [CW-1:0]               cnt_reg;
    logic [CW-1:0]               idx_reg;
    logic [IW-1:0]               ptr_reg;
    ffba_pkg::entry_t            cur_reg;
    logic                        func_reg;
    logic [24:0]                 need_reg;
    logic [ffba_pkg::ADDR_W-1:0] target_reg;
    logic                        null_reg;
    logic [ffba_pkg::ADDR_W-1:0] res_addr_reg;
    ffba_pkg::status_t           res_status_reg;

    logic [ffba_pkg::REQ_W-1:0]  req_bytes;
    logic [ffba_pkg::ADDR_W-1:0] rel_addr;
    logic [ffba_pkg::SIZE_W-1:0] cfg_bytes;
    logic [ffba_pkg::SIZE_W-1:0] size0;
    ffba_pkg::entry_t            rd_e;
    ffba_pkg::entry_t            wr_e;
    logic [EW-1:0]               rdata;
    logic [IW-1:0]               raddr;
    logic [IW-1:0]               waddr;
    logic                        we;
    logic [25:0]                 cur_end;

    assign req_bytes = s_tdata[23:0];
    assign rel_addr  = s_tdata[55:24];
    assign cfg_bytes = cfg_data[23:0];
    assign size0     = (26'(bytes_reg) > HDR) ? 24'(26'(bytes_reg) - HDR) : '0;
    assign rd_e      = ffba_pkg::entry_t'(rdata);
    assign cur_end   = 26'(cur_reg.off) + HDR + 26'(cur_reg.size);

    always_comb begin
        unique case (cmd.rd_sel)
            ffba_pkg::RD_IDX:    raddr = idx_reg[IW-1:0];
            ffba_pkg::RD_PTR_DN: raddr = ptr_reg - IW'(1);
            ffba_pkg::RD_PTR_UP: raddr = ptr_reg + IW'(1);
            ffba_pkg::RD_NEXT:   raddr = idx_reg[IW-1:0] + IW'(1);
            default:             raddr = idx_reg[IW-1:0];
        endcase
    end

    always_comb begin
        we = init_reg || cmd.wr_en;
        if (init_reg) begin
            waddr = '0;
            wr_e  = '{free: 1'b1, size: size0, off: '0};
        end else begin
            unique case (cmd.wr_sel)
                ffba_pkg::WR_PTR: begin
                    waddr = ptr_reg;
                    wr_e  = rd_e;
                end
                ffba_pkg::WR_NEW: begin
                    waddr = idx_reg[IW-1:0] + IW'(1);
                    wr_e  = '{free: 1'b1,
                              size: 24'(26'(cur_reg.size) - 26'(need_reg) - HDR),
                              off:  23'(26'(cur_reg.off) + HDR + 26'(need_reg))};
                end
                default: begin
                    waddr = idx_reg[IW-1:0];
                    wr_e  = '{free: func_reg, size: cur_reg.size, off: cur_reg.off};
                end
            endcase
        end
    end

    ffba_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_table (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wr_e),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb begin
        sts.init_busy = init_reg;
        sts.func_free = func_reg;
        sts.is_null   = null_reg;
        sts.idx_end   = (idx_reg == cnt_reg);
        sts.fit       = rd_e.free && ({1'b0, rd_e.size} >= need_reg);
        sts.split     = (26'(rd_e.size) >= 26'(need_reg) + HDR + MINS)
                        && (cnt_reg < CW'(MAX_BLOCKS));
        sts.hit       = (ffba_pkg::ADDR_W'(rd_e.off) == target_reg);
        sts.has_next  = ((idx_reg + CW'(1)) < cnt_reg);
        sts.mergeable = rd_e.free && (cur_end == 26'(rd_e.off));
        sts.up_done   = (CW'(ptr_reg) == idx_reg + CW'(1));
        sts.dn_done   = (CW'(ptr_reg) + CW'(1) == cnt_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= '0;
            bytes_reg <= ffba_pkg::HEAP_LIMIT;
            init_reg  <= 1'b1;
            cnt_reg   <= CW'(1);
            idx_reg   <= '0;
            ptr_reg   <= '0;
        end else begin
            if (init_reg) begin
                init_reg <= 1'b0;
                cnt_reg  <= CW'(1);
            end
            if (cfg_valid) begin
                if (cfg_index == ffba_pkg::CFG_HEAP_BASE) begin
                    base_reg <= cfg_data;
                end else begin
                    bytes_reg <= (cfg_bytes > ffba_pkg::HEAP_LIMIT) ?
                                 ffba_pkg::HEAP_LIMIT : cfg_bytes;
                    init_reg  <= 1'b1;
                end
            end
            if (cmd.load) begin
                idx_reg <= '0;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (cmd.ptr_init_up) begin
                ptr_reg <= cnt_reg[IW-1:0];
            end else if (cmd.ptr_init_dn) begin
                ptr_reg <= idx_reg[IW-1:0] + IW'(1);
            end else if (cmd.ptr_dec) begin
                ptr_reg <= ptr_reg - IW'(1);
            end else if (cmd.ptr_inc) begin
                ptr_reg <= ptr_reg + IW'(1);
            end
            if (cmd.cnt_inc) begin
                cnt_reg <= cnt_reg + CW'(1);
            end else if (cmd.cnt_dec) begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg   <= s_tuser;
            need_reg   <= (25'(req_bytes) + AMSK) & ~AMSK;
            target_reg <= rel_addr - base_reg - ffba_pkg::ADDR_W'(HEADER_BYTES);
            null_reg   <= (rel_addr == '0);
        end
        if (cmd.cur_ld) begin
            cur_reg <= rd_e;
        end else if (cmd.cur_merge) begin
            cur_reg.size <= 24'(26'(cur_reg.size) + HDR + 26'(rd_e.size));
        end else if (cmd.cur_take_need) begin
            cur_reg.size <= need_reg[23:0];
        end
        if (cmd.res_ld) begin
            res_status_reg <= cmd.res_code;
            if (cmd.res_code == ffba_pkg::ST_DONE && func_reg == ffba_pkg::FN_ALLOC) begin
                res_addr_reg <= base_reg + ffba_pkg::ADDR_W'(cur_reg.off)
                                + ffba_pkg::ADDR_W'(HEADER_BYTES);
            end else begin
                res_addr_reg <= '0;
            end
        end
    end

    assign res_address = res_addr_reg;
    assign res_status  = res_status_reg;

endmodule

>>> rtl/core/ffba_ctrl.sv
// Allocator controller: request sequencing state machine and output valid.
module ffba_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  ffba_pkg::sts_t sts,
    output ffba_pkg::cmd_t cmd
);

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_DECODE  = 13'b0000000000010,
        S_SCAN_RD = 13'b0000000000100,
        S_SCAN_EV = 13'b0000000001000,
        S_SH_RD   = 13'b0000000010000,
        S_SH_WR   = 13'b0000000100000,
        S_W_NEW   = 13'b0000001000000,
        S_W_CUR   = 13'b0000010000000,
        S_NX_RD   = 13'b0000100000000,
        S_NX_EV   = 13'b0001000000000,
        S_DN_RD   = 13'b0010000000000,
        S_DN_WR   = 13'b0100000000000,
        S_FIN     = 13'b1000000000000
    } state_t;

    state_t            state_reg, state_next;
    ffba_pkg::status_t code_reg, code_next;
    logic              m_valid_reg, m_valid_next;
    logic              accept;

    assign s_tready = (state_reg == S_IDLE) && !sts.init_busy;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        code_next    = code_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cmd          = '0;
        cmd.rd_sel   = ffba_pkg::RD_IDX;
        cmd.wr_sel   = ffba_pkg::WR_CUR;
        cmd.res_code = code_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (sts.func_free && sts.is_null) begin
                    code_next  = ffba_pkg::ST_NULL;
                    state_next = S_FIN;
                end else begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (sts.idx_end) begin
                    code_next  = sts.func_free ? ffba_pkg::ST_UNKNOWN : ffba_pkg::ST_NOFIT;
                    state_next = S_FIN;
                end else begin
                    cmd.rd_sel = ffba_pkg::RD_IDX;
                    state_next = S_SCAN_EV;
                end
            end
            S_SCAN_EV: begin
                if (!sts.func_free && sts.fit) begin
                    cmd.cur_ld = 1'b1;
                    if (sts.split) begin
                        cmd.ptr_init_up = 1'b1;
                        state_next      = S_SH_RD;
                    end else begin
                        state_next = S_W_CUR;
                    end
                end else if (sts.func_free && sts.hit) begin
                    cmd.cur_ld = 1'b1;
                    state_next = sts.has_next ? S_NX_RD : S_W_CUR;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end
            S_SH_RD: begin
                if (sts.up_done) begin
                    state_next = S_W_NEW;
                end else begin
                    cmd.rd_sel = ffba_pkg::RD_PTR_DN;
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = ffba_pkg::WR_PTR;
                cmd.ptr_dec = 1'b1;
                state_next  = S_SH_RD;
            end
            S_W_NEW: begin
                cmd.wr_en         = 1'b1;
                cmd.wr_sel        = ffba_pkg::WR_NEW;
                cmd.cur_take_need = 1'b1;
                cmd.cnt_inc       = 1'b1;
                state_next        = S_W_CUR;
            end
            S_W_CUR: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = ffba_pkg::WR_CUR;
                code_next  = ffba_pkg::ST_DONE;
                state_next = S_FIN;
            end
            S_NX_RD: begin
                cmd.rd_sel = ffba_pkg::RD_NEXT;
                state_next = S_NX_EV;
            end
            S_NX_EV: begin
                if (sts.mergeable) begin
                    cmd.cur_merge   = 1'b1;
                    cmd.ptr_init_dn = 1'b1;
                    state_next      = S_DN_RD;
                end else begin
                    state_next = S_W_CUR;
                end
            end
            S_DN_RD: begin
                if (sts.dn_done) begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_W_CUR;
                end else begin
                    cmd.rd_sel = ffba_pkg::RD_PTR_UP;
                    state_next = S_DN_WR;
                end
            end
            S_DN_WR: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = ffba_pkg::WR_PTR;
                cmd.ptr_inc = 1'b1;
                state_next  = S_DN_RD;
            end
            S_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.res_ld   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            code_reg    <= ffba_pkg::ST_DONE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            code_reg    <= code_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

>>> rtl/core/first_fit_block_allocator.sv
// First-fit heap block allocator with split and coalesce, top level.
//
// Requests arrive on the s_ stream: s_tuser selects allocate (0) or free (1),
// s_tdata carries the request size and the payload address to release.
// One word per request leaves on the m_ stream: m_tdata is the payload
// address, m_tuser the status. The cfg_ channel writes heap_base (index 0)
// and heap_bytes (index 1); a heap_bytes write rebuilds the table as one
// free block, and s_tready stays low while it does.
// After reset the same table setup runs before the first request.
// A request is handled one at a time. The block table has a registered
// read, so the scan and the moves spend a read state and then an
// evaluate or write state on each entry. A null free goes from the
// decode state straight to the result. The next request is accepted in
// the cycle after the result word is loaded at the earliest.
// A finished word sits in the output register; the block accepts the next
// request while it waits, and holds that request's result until the
// receiver takes the earlier word.
`include "first_fit_block_allocator_defines.svh"

module first_fit_block_allocator #(
    parameter int MAX_BLOCKS      = ffba_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES    = ffba_pkg::HEADER_BYTES_DEF,
    parameter int MIN_SPLIT_BYTES = ffba_pkg::MIN_SPLIT_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // request_bytes[23:0], release_address[55:24]
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // result_address[31:0]
    output logic [1:0]  m_tuser    // status[1:0]
);

    ffba_pkg::cmd_t    cmd;
    ffba_pkg::sts_t    sts;
    ffba_pkg::status_t res_status;

    assign cfg_ready = 1'b1;
    assign m_tuser   = res_status;

    ffba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ffba_dpath #(
        .MAX_BLOCKS      (MAX_BLOCKS),
        .HEADER_BYTES    (HEADER_BYTES),
        .MIN_SPLIT_BYTES (MIN_SPLIT_BYTES)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cmd         (cmd),
        .sts         (sts),
        .res_address (m_tdata),
        .res_status  (res_status)
    );

    `FFBA_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `FFBA_ASSERT_NEXT(a_busy_after_resize, aclk, aresetn,
        cfg_valid && cfg_ready && cfg_index == ffba_pkg::CFG_HEAP_BYTES, !s_tready)
    `FFBA_ASSERT_NOW(a_fail_addr_zero, aclk, aresetn,
        m_tvalid && m_tuser != ffba_pkg::ST_DONE, m_tdata == 32'd0)

endmodule

>>> tb/tb_first_fit_block_allocator.sv
// Self-checking testbench for the first-fit heap block allocator.
module tb_first_fit_block_allocator;
    timeunit 1ns;
    timeprecision 1ps;
    import ffba_pkg::*;

    localparam int NBLK = MAX_BLOCKS_DEF;
    localparam int HDR  = HEADER_BYTES_DEF;
    localparam int MINS = MIN_SPLIT_BYTES_DEF;

    typedef struct {
        logic [31:0] addr;
        status_t     st;
    } alloc_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    first_fit_block_allocator dut (.*);

    always #6 aclk = ~aclk;

    // Shadow copy of the block table and registers.
    logic [31:0] heap_base_r;
    logic [31:0] heap_bytes_r;
    logic [31:0] blk_off  [NBLK];
    logic [31:0] blk_size [NBLK];
    logic        blk_free [NBLK];
    int          blk_cnt;

    alloc_word_t  pending_results[$];
    logic [31:0]  live_addrs[$];
    logic [31:0]  stale_addrs[$];
    int           mismatches = 0;
    int           words_seen = 0;
    int           items_sent = 0;
    int           hold_len = 0;
    int           long_hold = 0;
    bit           no_idle = 1'b0;

    function automatic void rebuild_table();
        for (int i = 0; i < NBLK; i++) begin
            blk_off[i] = 0;
            blk_size[i] = 0;
            blk_free[i] = 1'b0;
        end
        blk_size[0] = (heap_bytes_r > HDR) ? heap_bytes_r - HDR : 0;
        blk_free[0] = 1'b1;
        blk_cnt = 1;
    endfunction

    function automatic void apply_config(input cfg_index_t idx, input logic [31:0] val);
        logic [31:0] v;
        v = {8'd0, val[23:0]};
        if (idx == CFG_HEAP_BASE) begin
            heap_base_r = val;
        end else begin
            heap_bytes_r = (v > 32'd8388608) ? 32'd8388608 : v;
            rebuild_table();
        end
    endfunction

    function automatic alloc_word_t predict_alloc(input logic [23:0] req);
        alloc_word_t r;
        logic [31:0] need;
        logic [31:0] sz;
        r.addr = 0;
        r.st = ST_NOFIT;
        need = ({8'd0, req} + 32'd7) & ~32'd7;
        for (int i = 0; i < blk_cnt; i++) begin
            if (blk_free[i] && blk_size[i] >= need) begin
                sz = blk_size[i];
                if (sz >= need + HDR + MINS && blk_cnt < NBLK) begin
                    for (int j = blk_cnt; j > i + 1; j--) begin
                        blk_off[j] = blk_off[j-1];
                        blk_size[j] = blk_size[j-1];
                        blk_free[j] = blk_free[j-1];
                    end
                    blk_off[i+1] = blk_off[i] + HDR + need;
                    blk_size[i+1] = sz - need - HDR;
                    blk_free[i+1] = 1'b1;
                    blk_size[i] = need;
                    blk_cnt++;
                end
                blk_free[i] = 1'b0;
                r.addr = heap_base_r + blk_off[i] + HDR;
                r.st = ST_DONE;
                return r;
            end
        end
        return r;
    endfunction

    function automatic alloc_word_t predict_release(input logic [31:0] a);
        alloc_word_t r;
        logic [31:0] target;
        int i;
        r.addr = 0;
        r.st = ST_DONE;
        if (a == 0) begin
            r.st = ST_NULL;
            return r;
        end
        target = a - heap_base_r - HDR;
        for (i = 0; i < blk_cnt; i++)
            if (blk_off[i] == target) break;
        if (i >= blk_cnt) begin
            r.st = ST_UNKNOWN;
            return r;
        end
        blk_free[i] = 1'b1;
        if (i + 1 < blk_cnt && blk_free[i+1] && blk_off[i] + HDR + blk_size[i] == blk_off[i+1])
        begin
            blk_size[i] = blk_size[i] + HDR + blk_size[i+1];
            for (int j = i + 1; j + 1 < blk_cnt; j++) begin
                blk_off[j] = blk_off[j+1];
                blk_size[j] = blk_size[j+1];
                blk_free[j] = blk_free[j+1];
            end
            blk_off[blk_cnt-1] = 0;
            blk_size[blk_cnt-1] = 0;
            blk_free[blk_cnt-1] = 1'b0;
            blk_cnt--;
        end
        return r;
    endfunction

    task automatic send_request(input func_t f, input logic [23:0] req, input logic [31:0] a);
        alloc_word_t r;
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {a, req};
        do @(posedge aclk); while (!s_tready);
        if (f == FN_ALLOC) begin
            r = predict_alloc(req);
            if (r.st == ST_DONE) live_addrs.push_back(r.addr);
        end else begin
            r = predict_release(a);
        end
        pending_results.push_back(r);
        items_sent++;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
        wait_drained();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        apply_config(idx, val);
        if (idx == CFG_HEAP_BYTES) begin
            live_addrs.delete();
            stale_addrs.delete();
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic release_live();
        int k;
        k = $urandom_range(0, live_addrs.size() - 1);
        stale_addrs.push_back(live_addrs[k]);
        send_request(FN_FREE, 24'($urandom), live_addrs[k]);
        live_addrs.delete(k);
    endtask

    // Counts down a long receiver hold-off, one cycle per clock.
    always @(negedge aclk) begin
        if (long_hold > 0) begin
            long_hold <= long_hold - 1;
        end
    end

    // Receiver: short bursts of stalls, plus the long hold-off when requested.
    always @(negedge aclk) begin
        if (long_hold > 0) begin
            m_tready <= 1'b0;
        end else if (hold_len > 0) begin
            m_tready <= 1'b0;
            hold_len <= hold_len - 1;
        end else if (no_idle) begin
            m_tready <= 1'b1;
        end else if (!m_tready) begin
            m_tready <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            hold_len <= $urandom_range(0, 10);
        end
    end

    always @(posedge aclk) begin
        alloc_word_t e;
        if (aresetn && m_tvalid && m_tready) begin
            words_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: addr=%h status=%0d", m_tdata, m_tuser);
            end else begin
                e = pending_results.pop_front();
                if (m_tdata !== e.addr || m_tuser !== e.st) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected addr=%h status=%0d, got addr=%h status=%0d",
                                 e.addr, e.st, m_tdata, m_tuser);
                end
            end
        end
    end

    task automatic test_basic_requests();
        send_request(FN_ALLOC, 24'd0, 32'hFFFF_FFFF);
        send_request(FN_ALLOC, 24'd1, 32'd0);
        send_request(FN_ALLOC, 24'd8388608, 32'd0);
        send_request(FN_ALLOC, 24'hFF_FFFF, 32'd0);
        send_request(FN_ALLOC, 24'd8388596 - 24'd64, 32'd0);
        send_request(FN_FREE, 24'hFF_FFFF, 32'd0);
        send_request(FN_FREE, 24'd0, 32'hFFFF_FFFF);
        send_request(FN_FREE, 24'd0, 32'd13);
        send_request(FN_FREE, 24'd0, 32'd28);
        send_request(FN_FREE, 24'd0, 32'd28);
        send_request(FN_FREE, 24'd0, 32'd12);
        send_request(FN_FREE, 24'd0, 32'd12);
        send_request(FN_ALLOC, 24'd100, 32'd0);
    endtask

    task automatic test_heap_extremes();
        write_reg(CFG_HEAP_BYTES, 32'd64);
        send_request(FN_ALLOC, 24'd40, 32'd0);
        send_request(FN_ALLOC, 24'd0, 32'd0);
        write_reg(CFG_HEAP_BYTES, 32'd12);
        send_request(FN_ALLOC, 24'd1, 32'd0);
        send_request(FN_ALLOC, 24'd0, 32'd0);
        write_reg(CFG_HEAP_BYTES, 32'hAB_FF_FFFF);
        send_request(FN_ALLOC, 24'd8388600, 32'd0);
        send_request(FN_ALLOC, 24'd8388590, 32'd0);
    endtask

    task automatic test_base_wrap();
        write_reg(CFG_HEAP_BYTES, 32'd4096);
        write_reg(CFG_HEAP_BASE, 32'hFFFF_FFF0);
        send_request(FN_ALLOC, 24'd16, 32'd0);
        send_request(FN_ALLOC, 24'd16, 32'd0);
        write_reg(CFG_HEAP_BASE, 32'h8000_0000);
        send_request(FN_FREE, 24'd0, 32'h8000_000C);
        send_request(FN_ALLOC, 24'd8, 32'd0);
    endtask

    task automatic test_table_full();
        write_reg(CFG_HEAP_BASE, 32'd0);
        write_reg(CFG_HEAP_BYTES, 32'd8388608);
        for (int i = 0; i < NBLK + 3; i++)
            send_request(FN_ALLOC, 24'($urandom_range(0, 9)), 32'd0);
        while (live_addrs.size() > 0) release_live();
    endtask

    task automatic test_backpressure();
        wait_drained();
        @(negedge aclk);
        long_hold = 400;
        for (int i = 0; i < 12; i++)
            send_request(FN_ALLOC, 24'($urandom_range(0, 32)), 32'd0);
        wait_drained();
    endtask

    task automatic test_random_mix();
        logic [31:0] sizes[6];
        int pick;
        sizes = '{32'd64, 32'd512, 32'd4096, 32'd65536, 32'd8388608, 32'd0};
        for (int p = 0; p < 6; p++) begin
            if (p == 5) no_idle = 1'b1;
            write_reg(CFG_HEAP_BASE, (p % 2) ? $urandom : 32'($urandom_range(0, 255)) << 4);
            write_reg(CFG_HEAP_BYTES, p == 5 ? {8'($urandom_range(0, 255)),
                      24'($urandom_range(64, 8388608))} : sizes[p]);
            for (int n = 0; n < 215; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    case ($urandom_range(0, 19))
                        0:       send_request(FN_ALLOC, 24'($urandom), $urandom);
                        1:       send_request(FN_ALLOC, 24'($urandom_range(0, heap_bytes_r)),
                                              $urandom);
                        2, 3, 4: send_request(FN_ALLOC, 24'($urandom_range(0, 1024)), $urandom);
                        default: send_request(FN_ALLOC, 24'($urandom_range(0, 64)), $urandom);
                    endcase
                end else if (pick < 90 && live_addrs.size() > 0) begin
                    release_live();
                end else begin
                    case ($urandom_range(0, 3))
                        0: send_request(FN_FREE, 24'($urandom), 32'd0);
                        1: send_request(FN_FREE, 24'($urandom), $urandom);
                        default: begin
                            if (stale_addrs.size() > 0)
                                send_request(FN_FREE, 24'($urandom),
                                    stale_addrs[$urandom_range(0, stale_addrs.size() - 1)]);
                            else
                                send_request(FN_FREE, 24'($urandom), heap_base_r + HDR);
                        end
                    endcase
                end
            end
        end
    endtask

    initial begin
        heap_base_r = 0;
        heap_bytes_r = 32'd8388608;
        rebuild_table();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_basic_requests();
        test_heap_extremes();
        test_base_wrap();
        test_table_full();
        test_backpressure();
        test_random_mix();
        wait_drained();
        repeat (600) @(posedge aclk);
        $display("Ran %0d requests (%0d words checked) over heap sizes from tiny to clamped,",
                 items_sent, words_seen);
        $display("with base wrap, full table, double and unknown frees, and stalls.");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches, %0d words missing", mismatches, pending_results.size());
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("run did not finish in time");
        $display("TB_ERROR");
        $finish;
    end
endmodule
